### rtl/core/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and constants for the ordered list with indexed delete: beat
// layouts, operation and status codes, and the cell shift modes.
// ----------------------------------------------------------------------------
package olid_pkg;

    localparam int OLID_DEPTH = 64;
    localparam int DATA_W     = 32;
    localparam int OP_W       = 3;
    localparam int IDX_W      = 8;
    localparam int STATUS_W   = 2;

    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [OP_W-1:0] OP_FORWARD = 3'd2;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
    localparam logic [OP_W-1:0] OP_MAXIMUM = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } out_beat_t;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_LEFT,
        CM_RIGHT,
        CM_LOAD,
        CM_CLOSE
    } cell_mode_t;

endpackage

### rtl/core/olid_cell.sv
// ----------------------------------------------------------------------------
// olid_cell
// One list slot: holds a value and takes it from a neighbor, from the append
// value, or keeps it, as the shared shift mode and its own position decide.
// ----------------------------------------------------------------------------
module olid_cell
    import olid_pkg::*;
#(
    parameter int POS   = 0,
    parameter int CNT_W = 7,
    parameter int IW    = 8
) (
    input  logic                     aclk,
    input  cell_mode_t               mode,
    input  logic [CNT_W-1:0]         count,
    input  logic [IW-1:0]            index_ext,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] from_prev,
    input  logic signed [DATA_W-1:0] from_next,
    output logic signed [DATA_W-1:0] data_out
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (mode)
            CM_HOLD:  data_next = data_reg;
            CM_LEFT:  data_next = from_next;
            CM_RIGHT: data_next = from_prev;
            CM_LOAD: begin
                if (count == CNT_W'(POS)) begin
                    data_next = value;
                end
            end
            CM_CLOSE: begin
                if (IW'(POS) >= index_ext) begin
                    data_next = from_next;
                end
            end
            default:  data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

### rtl/core/olid_chain.sv
// ----------------------------------------------------------------------------
// olid_chain
// Ring of DEPTH cells; entry 0 of the list rests in cell 0. Exposes the
// head cell and the far end of the ring as the two read points.
// ----------------------------------------------------------------------------
module olid_chain
    import olid_pkg::*;
#(
    parameter int DEPTH = OLID_DEPTH,
    parameter int CNT_W = 7,
    parameter int IW    = 8
) (
    input  logic                     aclk,
    input  cell_mode_t               mode,
    input  logic [CNT_W-1:0]         count,
    input  logic [IW-1:0]            index_ext,
    input  logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] head,
    output logic signed [DATA_W-1:0] tail
);

    logic signed [DATA_W-1:0] cell_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int PREV = (g == 0) ? DEPTH - 1 : g - 1;
        localparam int NEXT = (g == DEPTH - 1) ? 0 : g + 1;

        olid_cell #(
            .POS   (g),
            .CNT_W (CNT_W),
            .IW    (IW)
        ) u_cell (
            .aclk      (aclk),
            .mode      (mode),
            .count     (count),
            .index_ext (index_ext),
            .value     (value),
            .from_prev (cell_data[PREV]),
            .from_next (cell_data[NEXT]),
            .data_out  (cell_data[g])
        );
    end

    assign head = cell_data[0];
    assign tail = cell_data[DEPTH-1];

endmodule

### rtl/core/ordered_list_indexed_delete_top.sv
// ----------------------------------------------------------------------------
// ordered_list_indexed_delete_top
// Ordered list of signed 32-bit values held in a ring of cells.
// ----------------------------------------------------------------------------
// Takes one command beat at a time. Append, delete, emit forward, emit
// reverse and maximum each make one full turn of the cell ring, one position
// per cycle while the result side accepts; an append, after writing the
// tail, streams the list during that turn. Refused commands (empty, full,
// bad index) skip the turn and go straight to their result beat, and an
// undefined op is dropped with no result. The ring advances only while the
// result register is free or being emptied, so back-pressure on the result
// side stretches the turn. A new command is taken only once the previous one
// has finished its full turn and handed its final result beat to the output
// register.
module ordered_list_indexed_delete_top
    import olid_pkg::*;
#(
    parameter int DEPTH = OLID_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_payload
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int K_W   = $clog2(DEPTH);
    localparam int IW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_PASS,
        S_CLOSE,
        S_RESULT
    } state_t;

    state_t                   state_reg,    state_next;
    logic [CNT_W-1:0]         count_reg,    count_next;
    logic [K_W-1:0]           step_reg,     step_next;
    logic [OP_W-1:0]          op_reg,       op_next;
    logic signed [DATA_W-1:0] value_reg,    value_next;
    logic [IDX_W-1:0]         index_reg,    index_next;
    logic signed [DATA_W-1:0] best_reg,     best_next;
    logic signed [DATA_W-1:0] res_data_reg, res_data_next;
    logic [STATUS_W-1:0]      res_st_reg,   res_st_next;
    logic                     m_valid_reg,  m_valid_next;
    out_beat_t                m_payload_reg, m_payload_next;

    cell_mode_t               mode;
    logic signed [DATA_W-1:0] head;
    logic signed [DATA_W-1:0] tail;
    logic [IW-1:0]            index_ext;
    logic [CNT_W-1:0]         step_ext;
    logic                     out_free;

    assign index_ext = IW'(index_reg);
    assign step_ext  = CNT_W'(step_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);

    olid_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .IW    (IW)
    ) u_chain (
        .aclk      (aclk),
        .mode      (mode),
        .count     (count_reg),
        .index_ext (index_ext),
        .value     (value_reg),
        .head      (head),
        .tail      (tail)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        index_next     = index_reg;
        best_next      = best_reg;
        res_data_next  = res_data_reg;
        res_st_next    = res_st_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        mode           = CM_HOLD;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_payload.op;
                    value_next = s_payload.value;
                    index_next = s_payload.index;
                    if (s_payload.op <= OP_MAXIMUM) begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                step_next     = '0;
                res_data_next = '0;
                res_st_next   = ST_OK;
                if (op_reg == OP_APPEND) begin
                    if (count_reg == CNT_W'(DEPTH)) begin
                        res_st_next = ST_FULL;
                        state_next  = S_RESULT;
                    end else begin
                        mode       = CM_LOAD;
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_PASS;
                    end
                end else if (count_reg == '0) begin
                    res_st_next = ST_EMPTY;
                    state_next  = S_RESULT;
                end else if (op_reg == OP_DELETE && index_ext >= IW'(count_reg)) begin
                    res_st_next = ST_RANGE;
                    state_next  = S_RESULT;
                end else begin
                    state_next = S_PASS;
                end
            end
            S_PASS: begin
                if (out_free) begin
                    mode      = (op_reg == OP_REVERSE) ? CM_RIGHT : CM_LEFT;
                    step_next = step_reg + K_W'(1);
                    case (op_reg)
                        OP_APPEND, OP_FORWARD: begin
                            if (step_ext < count_reg) begin
                                m_valid_next          = 1'b1;
                                m_payload_next.data   = head;
                                m_payload_next.status = ST_OK;
                                m_payload_next.last   = (step_ext == count_reg - CNT_W'(1));
                            end
                        end
                        OP_REVERSE: begin
                            if (step_ext >= CNT_W'(DEPTH) - count_reg) begin
                                m_valid_next          = 1'b1;
                                m_payload_next.data   = tail;
                                m_payload_next.status = ST_OK;
                                m_payload_next.last   = (step_reg == K_W'(DEPTH - 1));
                            end
                        end
                        OP_MAXIMUM: begin
                            if (step_ext < count_reg &&
                                (step_reg == '0 || head > best_reg)) begin
                                best_next = head;
                            end
                        end
                        OP_DELETE: begin
                            if (IW'(step_reg) == index_ext) begin
                                res_data_next = head;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (step_reg == K_W'(DEPTH - 1)) begin
                        case (op_reg)
                            OP_MAXIMUM: begin
                                res_data_next = best_next;
                                state_next    = S_RESULT;
                            end
                            OP_DELETE: state_next = S_CLOSE;
                            default:   state_next = S_IDLE;
                        endcase
                    end
                end
            end
            S_CLOSE: begin
                mode       = CM_CLOSE;
                count_next = count_reg - CNT_W'(1);
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_payload_next.data   = res_data_reg;
                    m_payload_next.status = res_st_reg;
                    m_payload_next.last   = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        step_reg      <= step_next;
        op_reg        <= op_next;
        value_reg     <= value_next;
        index_reg     <= index_next;
        best_reg      <= best_next;
        res_data_reg  <= res_data_next;
        res_st_reg    <= res_st_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_ring_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PASS && m_valid_reg && !m_ready) |=> $stable(step_reg))
        else $error("ring advanced while result stalled");

    a_append_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE && op_reg == OP_APPEND && count_reg != CNT_W'(DEPTH))
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow the list");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.status != ST_OK) |-> m_payload_reg.data == '0)
        else $error("nonzero data on error beat");

endmodule
